// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ssoc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ssoc_pkg;

    localparam int RANGE_W     = 16;
    localparam int IDX_W       = 10;
    localparam int SUM_W       = 26;
    localparam int THR_W       = 16;
    localparam int CFG_ADDR_W  = 3;
    localparam int OUT_DATA_W  = 88;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LEFT_START   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LEFT_END     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_START = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_END   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_START  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_END    = 3'd6;

    localparam logic [THR_W-1:0]   THRESHOLD_RESET = 16'd300;
    localparam logic [RANGE_W-1:0] SMALL_RANGE_MM  = 16'd10;

    // floor(p / 5) = (p * 52429) >> 18, exact for p below 2^18
    localparam logic [RANGE_W-1:0] DIV5_MAGIC = 16'd52429;
    localparam int                 DIV5_SHIFT = 18;

    typedef struct packed {
        logic [IDX_W-1:0] left_start;
        logic [IDX_W-1:0] left_end;
        logic [IDX_W-1:0] center_start;
        logic [IDX_W-1:0] center_end;
        logic [IDX_W-1:0] right_start;
        logic [IDX_W-1:0] right_end;
    } win_cfg_t;

    typedef struct packed {
        logic [SUM_W-1:0] left;
        logic [SUM_W-1:0] center;
        logic [SUM_W-1:0] right;
    } limits_t;

    typedef struct packed {
        logic [RANGE_W-1:0] corr;
        logic               in_left;
        logic               in_center;
        logic               in_right;
        logic               last;
    } entry_t;

    // threshold * width; zero for an empty window so that no sum is below it
    function automatic logic [SUM_W-1:0] win_limit(input logic [THR_W-1:0] thr,
                                                   input logic [IDX_W-1:0] lo,
                                                   input logic [IDX_W-1:0] hi);
        logic [IDX_W-1:0] diff;
        logic [SUM_W-1:0] width;
        logic [SUM_W-1:0] thr_ext;
        diff    = hi - lo;
        width   = {{(SUM_W-IDX_W){1'b0}}, diff};
        thr_ext = {{(SUM_W-THR_W){1'b0}}, thr};
        if (hi > lo)
            return thr_ext * width;
        else
            return '0;
    endfunction

    // floor(6 * p / 5) = p + floor(p / 5), saturated to the range width
    function automatic logic [RANGE_W-1:0] scale_6_5(input logic [RANGE_W-1:0] p);
        logic [2*RANGE_W-1:0] prod;
        logic [RANGE_W:0]     sum;
        prod = {{RANGE_W{1'b0}}, p} * {{RANGE_W{1'b0}}, DIV5_MAGIC};
        sum  = {1'b0, p} + {{(RANGE_W+1-(2*RANGE_W-DIV5_SHIFT)){1'b0}},
                            prod[2*RANGE_W-1:DIV5_SHIFT]};
        if (sum[RANGE_W])
            return '1;
        else
            return sum[RANGE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ssoc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ssoc_front
    import ssoc_pkg::*;
#(
    parameter int SCAN_LEN = 1024
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [RANGE_W-1:0] in_range,
    input  wire logic               in_last,
    input  wire win_cfg_t           win,
    input  wire logic               q_full,
    output logic                    in_ready,
    output logic                    push,
    output entry_t                  push_entry
);

    localparam int CNT_W = $clog2(SCAN_LEN + 1);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SCAN_LEN);

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [RANGE_W-1:0] prev_reg, prev_next;
    logic [CMP_W-1:0]   idx;
    logic               in_scan;
    logic               fill_in;
    logic [RANGE_W-1:0] corr;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    assign idx     = CMP_W'(count_reg);
    assign in_scan = count_reg < CNT_MAX;
    // dropout: a tiny reading past the first index takes 6/5 of the previous corrected value
    assign fill_in = (in_range <= SMALL_RANGE_MM) && (count_reg != '0);
    assign corr    = fill_in ? scale_6_5(prev_reg) : in_range;

    always_comb
    begin
        push_entry.corr      = corr;
        push_entry.in_left   = in_scan && (idx >= CMP_W'(win.left_start))
                               && (idx < CMP_W'(win.left_end));
        push_entry.in_center = in_scan && (idx >= CMP_W'(win.center_start))
                               && (idx < CMP_W'(win.center_end));
        push_entry.in_right  = in_scan && (idx >= CMP_W'(win.right_start))
                               && (idx < CMP_W'(win.right_end));
        push_entry.last      = in_last;
    end

    always_comb
    begin
        count_next = count_reg;
        prev_next  = prev_reg;
        if (push)
        begin
            prev_next = corr;
            if (in_last)
                count_next = '0;
            else if (in_scan)
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            prev_reg  <= prev_next;
        end
    end

    `ASSERT_NEXT(a_index_clear, push && in_last, count_reg == '0,
                 "sample index not cleared after last sample")
    `ASSERT_IMPL(a_index_bound, 1'b1, count_reg <= CNT_MAX,
                 "sample index past scan length")

endmodule

`default_nettype wire

// ===== rtl/core/ssoc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ssoc_queue
    import ssoc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output logic        full,
    output logic        head_valid,
    output entry_t      head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    entry_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == CNT_FULL;
    assign head_valid = count_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_IMPL(a_no_overflow, push, !full || pop, "push into full queue")
    `ASSERT_IMPL(a_no_underflow, pop, head_valid, "pop from empty queue")

endmodule

`default_nettype wire

// ===== rtl/core/ssoc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ssoc_back
    import ssoc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  head_valid,
    input  wire entry_t                head,
    input  wire limits_t               limits,
    input  wire logic                  out_ready,
    output logic                       pop,
    output logic                       out_valid,
    output logic [OUT_DATA_W-1:0]      out_data
);

    logic [SUM_W-1:0] left_acc_reg, left_acc_next;
    logic [SUM_W-1:0] center_acc_reg, center_acc_next;
    logic [SUM_W-1:0] right_acc_reg, right_acc_next;
    logic [SUM_W-1:0] left_sum, center_sum, right_sum;
    logic [SUM_W-1:0] corr_ext;
    logic             left_hit, center_hit, right_hit;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // a non-final sample never waits on the output side
    assign pop = head_valid && (!head.last || !out_valid_reg || out_ready);

    assign corr_ext   = {{(SUM_W-RANGE_W){1'b0}}, head.corr};
    assign left_sum   = left_acc_reg + (head.in_left ? corr_ext : '0);
    assign center_sum = center_acc_reg + (head.in_center ? corr_ext : '0);
    assign right_sum  = right_acc_reg + (head.in_right ? corr_ext : '0);

    assign left_hit   = left_sum < limits.left;
    assign center_hit = center_sum < limits.center;
    assign right_hit  = right_sum < limits.right;

    always_comb
    begin
        left_acc_next   = left_acc_reg;
        center_acc_next = center_acc_reg;
        right_acc_next  = right_acc_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        if (pop)
        begin
            if (head.last)
            begin
                left_acc_next   = '0;
                center_acc_next = '0;
                right_acc_next  = '0;
                out_valid_next  = 1'b1;
                out_data_next   = {{(OUT_DATA_W-6-3*SUM_W){1'b0}},
                                   right_sum, center_sum, left_sum,
                                   right_hit, center_hit, left_hit,
                                   left_hit, right_hit, center_hit};
            end
            else
            begin
                left_acc_next   = left_sum;
                center_acc_next = center_sum;
                right_acc_next  = right_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_acc_reg   <= '0;
            center_acc_reg <= '0;
            right_acc_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            left_acc_reg   <= left_acc_next;
            center_acc_reg <= center_acc_next;
            right_acc_reg  <= right_acc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_NEXT(a_acc_clear, pop && head.last,
                 left_acc_reg == '0 && center_acc_reg == '0 && right_acc_reg == '0,
                 "window sums not cleared after scan end")
    `ASSERT_NEXT(a_result_loaded, pop && head.last, out_valid_reg,
                 "scan end popped without a result")

endmodule

`default_nettype wire

// ===== rtl/core/scan_sector_obstacle_classifier.sv =====
// Path: each accepted sample is written into the queue; the last sample of a scan,
//   once earlier samples have left the queue, loads the result register behind m_tdata.
// Throughput: one sample per cycle while the queue is not full; a 4-entry queue lets
//   the sample side run on while a result waits for the taker, one result per scan.
// Reset: asynchronous, active low; clears index, sums, queue and output, and loads
//   the registers with threshold 300 mm and all window bounds 0.
`timescale 1ns / 1ps
`default_nettype none

module scan_sector_obstacle_classifier
    import ssoc_pkg::*;
#(
    parameter int SCAN_LEN = 1024
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [RANGE_W-1:0]    s_tdata,   // [15:0] range_mm
    input  wire logic                  s_tlast,   // last_sample
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [2:0] position_code, [3] left_hit, [4] center_hit, [5] right_hit,
    // [31:6] left_total, [57:32] center_total, [83:58] right_total, [87:84] zero
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_index,
    input  wire logic [THR_W-1:0]      cfg_data
);

    logic [THR_W-1:0] threshold_reg;
    win_cfg_t         win_reg;
    limits_t          limits_reg, limits_next;
    logic             cfg_write;
    logic             q_full, q_push, q_pop, q_head_valid;
    entry_t           q_push_entry, q_head;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            win_reg       <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_THRESHOLD:    threshold_reg        <= cfg_data;
                REG_LEFT_START:   win_reg.left_start   <= cfg_data[IDX_W-1:0];
                REG_LEFT_END:     win_reg.left_end     <= cfg_data[IDX_W-1:0];
                REG_CENTER_START: win_reg.center_start <= cfg_data[IDX_W-1:0];
                REG_CENTER_END:   win_reg.center_end   <= cfg_data[IDX_W-1:0];
                REG_RIGHT_START:  win_reg.right_start  <= cfg_data[IDX_W-1:0];
                REG_RIGHT_END:    win_reg.right_end    <= cfg_data[IDX_W-1:0];
                default:          ;
            endcase
        end
    end

    // threshold * width per window, kept registered; a write reaches it through the setting registers
    always_comb
    begin
        limits_next.left   = win_limit(threshold_reg, win_reg.left_start, win_reg.left_end);
        limits_next.center = win_limit(threshold_reg, win_reg.center_start,
                                       win_reg.center_end);
        limits_next.right  = win_limit(threshold_reg, win_reg.right_start, win_reg.right_end);
    end

    always_ff @(posedge clk)
    begin
        limits_reg <= limits_next;
    end

    ssoc_front #(
        .SCAN_LEN (SCAN_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_range   (s_tdata),
        .in_last    (s_tlast),
        .win        (win_reg),
        .q_full     (q_full),
        .in_ready   (s_tready),
        .push       (q_push),
        .push_entry (q_push_entry)
    );

    ssoc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    ssoc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .limits     (limits_reg),
        .out_ready  (m_tready),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_data   (m_tdata)
    );

endmodule

`default_nettype wire

// ===== test/tb_scan_sector_obstacle_classifier.sv =====
`timescale 1ns / 1ps

module tb_scan_sector_obstacle_classifier;
    import ssoc_pkg::*;

    localparam int          SCAN_LEN     = 1024;
    localparam int unsigned RANGE_MAX    = (1 << RANGE_W) - 1;
    localparam int          GAP_MAX      = 18;
    localparam int          LONG_HOLD    = 600;
    localparam int          ITEM_TARGET  = 1250;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int          SETTLE       = 8;

    // index 7 decodes to no register
    localparam logic [CFG_ADDR_W-1:0] REG_NONE = 3'd7;

    localparam int WIN_LEFT   = 0;
    localparam int WIN_CENTER = 1;
    localparam int WIN_RIGHT  = 2;

    typedef struct {
        logic [RANGE_W-1:0] range_mm;
        logic               last_sample;
        int unsigned        gap;
    } range_sample_t;

    typedef struct {
        logic [2:0]       position_code;
        logic             left_hit;
        logic             center_hit;
        logic             right_hit;
        logic [SUM_W-1:0] left_total;
        logic [SUM_W-1:0] center_total;
        logic [SUM_W-1:0] right_total;
    } scan_summary_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [RANGE_W-1:0]    s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_index = '0;
    logic [THR_W-1:0]      cfg_data = '0;

    scan_sector_obstacle_classifier #(.SCAN_LEN(SCAN_LEN)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [THR_W-1:0] thr_mm;
    logic [IDX_W-1:0] win_lo [3];
    logic [IDX_W-1:0] win_hi [3];
    logic [SUM_W-1:0] window_sum [3];
    int unsigned      last_corrected;
    int unsigned      next_index;

    range_sample_t samples_to_send[$];
    scan_summary_t pending_summaries[$];

    int unsigned samples_queued = 0;
    int unsigned mismatches = 0;
    int unsigned sender_gap_max = 0;
    int unsigned taker_stall_max = 0;

    // handoff flags between the posedge monitor and the negedge drivers
    bit sample_taken = 1'b0;
    bit result_taken = 1'b0;
    bit offering = 1'b0;
    bit hold_request = 1'b0;
    int unsigned gap_count = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;

    function automatic void apply_register(input logic [CFG_ADDR_W-1:0] idx,
                                           input logic [THR_W-1:0] value);
        case (idx)
            REG_THRESHOLD:    thr_mm = value;
            REG_LEFT_START:   win_lo[WIN_LEFT] = value[IDX_W-1:0];
            REG_LEFT_END:     win_hi[WIN_LEFT] = value[IDX_W-1:0];
            REG_CENTER_START: win_lo[WIN_CENTER] = value[IDX_W-1:0];
            REG_CENTER_END:   win_hi[WIN_CENTER] = value[IDX_W-1:0];
            REG_RIGHT_START:  win_lo[WIN_RIGHT] = value[IDX_W-1:0];
            REG_RIGHT_END:    win_hi[WIN_RIGHT] = value[IDX_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void predict_scan_sample(input logic [RANGE_W-1:0] range_mm,
                                                input logic last_sample);
        int unsigned   corrected;
        logic [2:0]    hit;
        scan_summary_t s;
        corrected = 32'(range_mm);
        if (range_mm <= SMALL_RANGE_MM && next_index != 0)
        begin
            corrected = (last_corrected * 6) / 5;
            if (corrected > RANGE_MAX)
                corrected = RANGE_MAX;
        end
        last_corrected = corrected;
        // index stops at the scan length; later samples land in no window
        if (next_index < SCAN_LEN)
        begin
            for (int w = 0; w < 3; w++)
                if (next_index >= win_lo[w] && next_index < win_hi[w])
                    window_sum[w] = SUM_W'(window_sum[w] + corrected);
            next_index++;
        end
        if (last_sample)
        begin
            for (int w = 0; w < 3; w++)
                hit[w] = (win_hi[w] > win_lo[w]) &&
                         (longint'(window_sum[w]) <
                          longint'(thr_mm) * longint'(win_hi[w] - win_lo[w]));
            s.position_code = {hit[WIN_LEFT], hit[WIN_RIGHT], hit[WIN_CENTER]};
            s.left_hit      = hit[WIN_LEFT];
            s.center_hit    = hit[WIN_CENTER];
            s.right_hit     = hit[WIN_RIGHT];
            s.left_total    = window_sum[WIN_LEFT];
            s.center_total  = window_sum[WIN_CENTER];
            s.right_total   = window_sum[WIN_RIGHT];
            pending_summaries.push_back(s);
            next_index = 0;
            for (int w = 0; w < 3; w++)
                window_sum[w] = '0;
        end
    endfunction

    function automatic void compare_field(input string name, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_summary(input logic [OUT_DATA_W-1:0] data);
        scan_summary_t want;
        if (pending_summaries.size() == 0)
        begin
            $display("%0t: unexpected result, expected none actual %h", $time, data);
            mismatches++;
        end
        else
        begin
            want = pending_summaries.pop_front();
            compare_field("position_code", want.position_code, data[2:0]);
            compare_field("left_hit", want.left_hit, data[3]);
            compare_field("center_hit", want.center_hit, data[4]);
            compare_field("right_hit", want.right_hit, data[5]);
            compare_field("left_total", want.left_total, data[6 +: SUM_W]);
            compare_field("center_total", want.center_total, data[6 + SUM_W +: SUM_W]);
            compare_field("right_total", want.right_total, data[6 + 2*SUM_W +: SUM_W]);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_scan_sample(s_tdata, s_tlast);
                sample_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                check_summary(m_tdata);
                result_taken = 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin : sample_driver
        range_sample_t item;
        if (rst_n)
        begin
            if (sample_taken)
            begin
                sample_taken = 1'b0;
                offering = 1'b0;
            end
            if (!offering && samples_to_send.size() != 0)
            begin
                if (gap_count < samples_to_send[0].gap)
                    gap_count++;
                else
                begin
                    item = samples_to_send.pop_front();
                    gap_count = 0;
                    s_tdata <= item.range_mm;
                    s_tlast <= item.last_sample;
                    offering = 1'b1;
                end
            end
            s_tvalid <= offering;
        end
    end

    always @(negedge clk)
    begin : result_taker
        if (rst_n)
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (result_taken)
            begin
                result_taken = 1'b0;
                stall_left = $urandom_range(0, taker_stall_max);
            end
            if (hold_left != 0)
                hold_left--;
            else if (stall_left != 0)
                stall_left--;
            m_tready <= (hold_left == 0 && stall_left == 0);
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                  input logic [THR_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_register(idx, value);
    endtask

    // upper data bits of a bound register are don't-care, so fill them at random
    task automatic load_settings(input logic [THR_W-1:0] thr, input win_cfg_t w);
        logic [THR_W-1:0] junk;
        junk = THR_W'($urandom);
        write_register(REG_THRESHOLD, thr);
        write_register(REG_LEFT_START, {junk[THR_W-1:IDX_W], w.left_start});
        write_register(REG_LEFT_END, {junk[THR_W-1:IDX_W], w.left_end});
        write_register(REG_CENTER_START, {junk[THR_W-1:IDX_W], w.center_start});
        write_register(REG_CENTER_END, {junk[THR_W-1:IDX_W], w.center_end});
        write_register(REG_RIGHT_START, {junk[THR_W-1:IDX_W], w.right_start});
        write_register(REG_RIGHT_END, {junk[THR_W-1:IDX_W], w.right_end});
        write_register(REG_NONE, junk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void push_sample(input logic [RANGE_W-1:0] range_mm,
                                        input logic last_sample);
        range_sample_t item;
        item.range_mm    = range_mm;
        item.last_sample = last_sample;
        item.gap         = $urandom_range(0, sender_gap_max);
        samples_to_send.push_back(item);
        samples_queued++;
    endfunction

    function automatic void queue_random_scan(input int max_len);
        int                 len;
        logic [RANGE_W-1:0] r;
        len = $urandom_range(1, max_len);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: r = RANGE_W'($urandom_range(0, SMALL_RANGE_MM));
                3:       r = RANGE_W'(SMALL_RANGE_MM + $urandom_range(0, 1));
                4:       r = RANGE_W'($urandom_range(60000, RANGE_MAX));
                default: r = RANGE_W'($urandom);
            endcase
            push_sample(r, i == len - 1);
        end
    endfunction

    function automatic logic [IDX_W-1:0] random_bound();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return IDX_W'($urandom_range(0, 48));
        endcase
    endfunction

    function automatic win_cfg_t random_windows();
        win_cfg_t w;
        w.left_start   = random_bound();
        w.left_end     = random_bound();
        w.center_start = random_bound();
        w.center_end   = random_bound();
        w.right_start  = random_bound();
        w.right_end    = random_bound();
        return w;
    endfunction

    function automatic logic [THR_W-1:0] random_threshold();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return THR_W'($urandom_range(0, 2000));
            default: return THR_W'($urandom);
        endcase
    endfunction

    task automatic wait_idle();
        while (samples_to_send.size() != 0 || offering || pending_summaries.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin : stimulus
        win_cfg_t    w;

        thr_mm = THRESHOLD_RESET;
        for (int i = 0; i < 3; i++)
        begin
            win_lo[i] = '0;
            win_hi[i] = '0;
            window_sum[i] = '0;
        end
        last_corrected = 0;
        next_index = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sender_gap_max  = GAP_MAX;
        taker_stall_max = GAP_MAX;

        // overlapping windows; first-sample exemption, small-range boundary,
        // 6/5 saturation, then a one-sample scan and a zero chain
        w = '{left_start: 0, left_end: 4, center_start: 2, center_end: 6,
              right_start: 5, right_end: 9};
        load_settings(THRESHOLD_RESET, w);
        push_sample(16'd5, 1'b0);
        push_sample(16'd0, 1'b0);
        push_sample(SMALL_RANGE_MM, 1'b0);
        push_sample(16'(SMALL_RANGE_MM + 1), 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'd2, 1'b0);
        push_sample(16'd60000, 1'b0);
        push_sample(16'd1, 1'b1);
        push_sample(16'd3, 1'b1);
        push_sample(16'd0, 1'b0);
        push_sample(16'd0, 1'b1);
        wait_idle();

        // empty and reversed windows, a window far past a short scan
        w = '{left_start: 5, left_end: 5, center_start: 9, center_end: 3,
              right_start: 0, right_end: 1023};
        load_settings(16'hFFFF, w);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'd0, 1'b0);
        push_sample(16'd40000, 1'b1);
        wait_idle();

        // zero threshold never flags
        w = '{left_start: 0, left_end: 1023, center_start: 0, center_end: 1,
              right_start: 1, right_end: 3};
        load_settings('0, w);
        push_sample(16'd0, 1'b0);
        push_sample(16'd0, 1'b0);
        push_sample(16'd0, 1'b1);
        wait_idle();

        // scan longer than the index range, then a short one to see the clear
        sender_gap_max = 0;
        w = '{left_start: 0, left_end: 1023, center_start: 1000, center_end: 1023,
              right_start: 1020, right_end: 1023};
        load_settings(16'hFFFF, w);
        for (int i = 0; i < SCAN_LEN + 6; i++)
            push_sample(16'($urandom), i == SCAN_LEN + 5);
        push_sample(16'd7, 1'b0);
        push_sample(16'd20, 1'b1);
        wait_idle();

        // back pressure: taker holds off while short scans stream in
        load_settings(random_threshold(), random_windows());
        @(posedge clk);
        hold_request = 1'b1;
        repeat (40) queue_random_scan(3);
        wait_idle();

        while (samples_queued < ITEM_TARGET)
        begin
            case ($urandom_range(0, 2))
                0:       sender_gap_max = 0;
                1:       sender_gap_max = 4;
                default: sender_gap_max = GAP_MAX;
            endcase
            case ($urandom_range(0, 2))
                0:       taker_stall_max = 0;
                1:       taker_stall_max = 4;
                default: taker_stall_max = GAP_MAX;
            endcase
            load_settings(random_threshold(), random_windows());
            repeat ($urandom_range(2, 8))
                queue_random_scan(($urandom_range(0, 7) == 0) ? 120 : 40);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (pending_summaries.size() != 0)
            $display("%0t: %0d results never arrived", $time, pending_summaries.size());
        if (mismatches == 0 && pending_summaries.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ssoc_pkg.sv
rtl/core/ssoc_front.sv
rtl/core/ssoc_queue.sv
rtl/core/ssoc_back.sv
rtl/core/scan_sector_obstacle_classifier.sv
test/tb_scan_sector_obstacle_classifier.sv
